FILE: hdl/task_ready_queue_assert.svh
// Assertion macros for the task ready queue checker.
`ifndef TASK_READY_QUEUE_ASSERT_SVH
`define TASK_READY_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define TRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define TRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/trq_pkg.sv
// Shared types, codes and microcode program of the task ready queue.
package trq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    localparam int CMD_W       = 2;
    localparam int TASK_ID_W   = 16;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;
    localparam int CMD_LSB     = 0;
    localparam int ID_LSB      = 2;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;
    typedef logic [3:0]      act_t;
    typedef logic [3:0]      cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        pc_t   target;
        logic  done;
    } ucode_t;

    localparam act_t A_NOP    = 4'd0;
    localparam act_t A_ACCEPT = 4'd1;
    localparam act_t A_ADV    = 4'd2;
    localparam act_t A_UNLINK = 4'd3;
    localparam act_t A_MISS   = 4'd4;
    localparam act_t A_FOUND  = 4'd5;
    localparam act_t A_EMPTY  = 4'd6;
    localparam act_t A_SCAN   = 4'd7;
    localparam act_t A_ENQ    = 4'd8;
    localparam act_t A_FULL   = 4'd9;

    localparam cond_t C_NONE   = 4'd0;
    localparam cond_t C_ALWAYS = 4'd1;
    localparam cond_t C_IDLE   = 4'd2;
    localparam cond_t C_ENQ    = 4'd3;
    localparam cond_t C_EMPTY  = 4'd4;
    localparam cond_t C_DEQ    = 4'd5;
    localparam cond_t C_MATCH  = 4'd6;
    localparam cond_t C_MORE   = 4'd7;
    localparam cond_t C_FIND   = 4'd8;
    localparam cond_t C_FULL   = 4'd9;
    localparam cond_t C_USED   = 4'd10;

    localparam pc_t P_WAIT    = 5'd0;
    localparam pc_t P_DISP0   = 5'd1;
    localparam pc_t P_DISP1   = 5'd2;
    localparam pc_t P_DISP2   = 5'd3;
    localparam pc_t P_WALK_RD = 5'd4;
    localparam pc_t P_WALK_CK = 5'd5;
    localparam pc_t P_WALK_NX = 5'd6;
    localparam pc_t P_MISS    = 5'd7;
    localparam pc_t P_HIT     = 5'd8;
    localparam pc_t P_REMOVE  = 5'd9;
    localparam pc_t P_FOUND   = 5'd10;
    localparam pc_t P_DEQ     = 5'd11;
    localparam pc_t P_EMPTY   = 5'd12;
    localparam pc_t P_ENQ     = 5'd13;
    localparam pc_t P_SCAN    = 5'd14;
    localparam pc_t P_LINK    = 5'd15;
    localparam pc_t P_FULL    = 5'd16;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        case (pc)
            P_WAIT:    w = '{act: A_ACCEPT, cond: C_IDLE,   target: P_WAIT,    done: 1'b0};
            P_DISP0:   w = '{act: A_NOP,    cond: C_ENQ,    target: P_ENQ,     done: 1'b0};
            P_DISP1:   w = '{act: A_NOP,    cond: C_EMPTY,  target: P_EMPTY,   done: 1'b0};
            P_DISP2:   w = '{act: A_NOP,    cond: C_DEQ,    target: P_DEQ,     done: 1'b0};
            P_WALK_RD: w = '{act: A_NOP,    cond: C_NONE,   target: P_WAIT,    done: 1'b0};
            P_WALK_CK: w = '{act: A_NOP,    cond: C_MATCH,  target: P_HIT,     done: 1'b0};
            P_WALK_NX: w = '{act: A_ADV,    cond: C_MORE,   target: P_WALK_RD, done: 1'b0};
            P_MISS:    w = '{act: A_MISS,   cond: C_ALWAYS, target: P_WAIT,    done: 1'b1};
            P_HIT:     w = '{act: A_NOP,    cond: C_FIND,   target: P_FOUND,   done: 1'b0};
            P_REMOVE:  w = '{act: A_UNLINK, cond: C_ALWAYS, target: P_WAIT,    done: 1'b1};
            P_FOUND:   w = '{act: A_FOUND,  cond: C_ALWAYS, target: P_WAIT,    done: 1'b1};
            P_DEQ:     w = '{act: A_NOP,    cond: C_ALWAYS, target: P_REMOVE,  done: 1'b0};
            P_EMPTY:   w = '{act: A_EMPTY,  cond: C_ALWAYS, target: P_WAIT,    done: 1'b1};
            P_ENQ:     w = '{act: A_NOP,    cond: C_FULL,   target: P_FULL,    done: 1'b0};
            P_SCAN:    w = '{act: A_SCAN,   cond: C_USED,   target: P_SCAN,    done: 1'b0};
            P_LINK:    w = '{act: A_ENQ,    cond: C_ALWAYS, target: P_WAIT,    done: 1'b1};
            P_FULL:    w = '{act: A_FULL,   cond: C_ALWAYS, target: P_WAIT,    done: 1'b1};
            default:   w = '{act: A_NOP,    cond: C_ALWAYS, target: P_WAIT,    done: 1'b0};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/trq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module trq_ram
    import trq_pkg::*;
#(
    parameter int WIDTH = TASK_ID_W,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/task_ready_queue.sv
// Flow from accepted word to result: dispatch, then empty/full reject, dequeue via remove,
// enqueue after a scan for the lowest free slot (scanned one slot a cycle), remove/find after
// a list walk that ends in a match at list position k or in a miss over all n entries.
// One command in flight; the list walk reads one slot RAM entry per read, check and advance step.
// Next word is taken in the cycle after the result register loads.
// Reset (synchronous, aresetn low) empties the queue; slot RAMs are not cleared.
module task_ready_queue
    import trq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cmd[1:0], task_id[17:2], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], result_id[17:2], queue_empty[18], pad
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (ID_BITS < TASK_ID_W) ? ID_BITS : TASK_ID_W;

    pc_t                 pc_reg, pc_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [SW-1:0]       id_reg, id_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       prev_reg, prev_next;
    logic [AW-1:0]       k_reg, k_next;
    logic [AW-1:0]       scan_reg, scan_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [DEPTH-1:0]    used_reg, used_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TASK_ID_W-1:0] rid_reg, rid_next;
    logic                empty_reg, empty_next;

    ucode_t              cw;
    logic                stall;
    logic                jump;
    logic [CW-1:0]       k_inc;

    logic                id_we;
    logic [AW-1:0]       id_waddr;
    logic [SW-1:0]       id_wdata;
    logic [SW-1:0]       id_rdata;
    logic                link_we;
    logic [AW-1:0]       link_waddr;
    logic [AW-1:0]       link_wdata;
    logic [AW-1:0]       link_rdata;

    trq_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_id_ram (
        .clk   (aclk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (cur_reg),
        .rdata (id_rdata)
    );

    trq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
        .clk   (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_reg),
        .rdata (link_rdata)
    );

    assign s_tready = aresetn && (pc_reg == P_WAIT);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({empty_reg, rid_reg, status_reg});

    always_comb begin
        cw    = ucode_rom(pc_reg);
        stall = cw.done && m_valid_reg && !m_tready;
        k_inc = CW'(k_reg) + CW'(1);

        case (cw.cond)
            C_NONE:   jump = 1'b0;
            C_ALWAYS: jump = 1'b1;
            C_IDLE:   jump = !s_tvalid;
            C_ENQ:    jump = (cmd_reg == CMD_ENQ);
            C_EMPTY:  jump = (count_reg == '0);
            C_DEQ:    jump = (cmd_reg == CMD_DEQ);
            C_MATCH:  jump = (id_rdata == id_reg);
            C_MORE:   jump = (k_inc < count_reg);
            C_FIND:   jump = (cmd_reg == CMD_FIND);
            C_FULL:   jump = (count_reg == CW'(DEPTH));
            C_USED:   jump = used_reg[scan_reg];
            default:  jump = 1'b0;
        endcase

        pc_next      = pc_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        k_next       = k_reg;
        scan_next    = scan_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        used_next    = used_reg;
        status_next  = status_reg;
        rid_next     = rid_reg;
        empty_next   = empty_reg;
        m_valid_next = m_valid_reg && !m_tready;
        id_we        = 1'b0;
        id_waddr     = scan_reg;
        id_wdata     = id_reg;
        link_we      = 1'b0;
        link_waddr   = tail_reg;
        link_wdata   = scan_reg;

        if (!stall) begin
            pc_next = jump ? cw.target : pc_reg + 1'b1;
            if (cw.done) begin
                m_valid_next = 1'b1;
                status_next  = ST_OK;
                rid_next     = '0;
                empty_next   = (count_reg == '0);
            end
            case (cw.act)
                A_NOP: begin
                end
                A_ACCEPT: begin
                    if (s_tvalid) begin
                        cmd_next  = s_tdata[CMD_LSB +: CMD_W];
                        id_next   = s_tdata[ID_LSB +: SW];
                        cur_next  = head_reg;
                        prev_next = head_reg;
                        k_next    = '0;
                        scan_next = '0;
                    end
                end
                A_ADV: begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    k_next    = k_reg + 1'b1;
                end
                A_UNLINK: begin
                    rid_next           = TASK_ID_W'(id_rdata);
                    used_next[cur_reg] = 1'b0;
                    count_next         = count_reg - 1'b1;
                    empty_next         = (count_reg == CW'(1));
                    if (count_reg == CW'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end else if (k_reg == '0) begin
                        head_next = link_rdata;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rdata;
                        if (cur_reg == tail_reg) begin
                            tail_next = prev_reg;
                        end
                    end
                end
                A_MISS: begin
                    status_next = ST_NOT_FOUND;
                end
                A_FOUND: begin
                    rid_next = TASK_ID_W'(id_rdata);
                end
                A_EMPTY: begin
                    status_next = ST_EMPTY;
                end
                A_SCAN: begin
                    if (used_reg[scan_reg]) begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                A_ENQ: begin
                    id_we               = 1'b1;
                    used_next[scan_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    tail_next           = scan_reg;
                    rid_next            = TASK_ID_W'(id_reg);
                    empty_next          = 1'b0;
                    if (count_reg == '0) begin
                        head_next = scan_reg;
                    end else begin
                        link_we = 1'b1;
                    end
                end
                A_FULL: begin
                    status_next = ST_FULL;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= P_WAIT;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        k_reg      <= k_next;
        scan_reg   <= scan_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        empty_reg  <= empty_next;
    end

endmodule

FILE: hdl/trq_checker.sv
// Port-level checker for the task ready queue, bound to the top level.
`include "task_ready_queue_assert.svh"

module trq_checker
    import trq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `TRQ_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `TRQ_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word taken while busy")
    `TRQ_ASSERT_NOW(a_fail_zero_id, m_tvalid && (m_tdata[1:0] != ST_OK), m_tdata[17:2] == '0, "failed command returned an id")
    `TRQ_ASSERT_NOW(a_empty_flag, m_tvalid && (m_tdata[1:0] == ST_EMPTY), m_tdata[18], "empty status without empty flag")
    `TRQ_ASSERT_NOW(a_full_flag, m_tvalid && (m_tdata[1:0] == ST_FULL), !m_tdata[18], "full status with empty flag")

endmodule

bind task_ready_queue trq_checker u_trq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
